FILE: design/assert_macros.svh
// Assertion macros used by the top-level design file.
// The clock is clk and the asynchronous reset is rst_n in every user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LCDW_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LCDW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lcdw_pkg.sv
// ---------------------------------------------------------------------------
// lcdw_pkg: shared types and constants of the window pixel writer
// Beat payload structs, register map, request codes and color expansion.
// ---------------------------------------------------------------------------
package lcdw_pkg;

    localparam int MAX_SIDE_DEFAULT = 1024;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PANEL_W    = 11;

    localparam logic [PANEL_W-1:0] PANEL_WIDTH_RESET  = 11'd240;
    localparam logic [PANEL_W-1:0] PANEL_HEIGHT_RESET = 11'd320;

    localparam logic REG_PANEL_WIDTH  = 1'b0;
    localparam logic REG_PANEL_HEIGHT = 1'b1;

    localparam logic REQ_WINDOW = 1'b0;
    localparam logic REQ_PIXEL  = 1'b1;

    localparam logic [15:0] RED_MASK   = 16'hf800;
    localparam logic [15:0] GREEN_MASK = 16'h07e0;
    localparam logic [15:0] BLUE_MASK  = 16'h001f;

    typedef struct packed {
        logic        req_type;
        logic [9:0]  win_x;
        logic [9:0]  win_y;
        logic [10:0] win_w;
        logic [10:0] win_h;
        logic [15:0] color565;
    } req_t;

    typedef struct packed {
        logic [19:0] pixel_address;
        logic [23:0] pixel_rgb888;
    } pix_t;

    typedef struct packed {
        logic [PANEL_W-1:0] width;
        logic [PANEL_W-1:0] height;
    } panel_t;

    typedef struct packed {
        logic               emit;
        logic [PANEL_W-1:0] col;
        logic [PANEL_W-1:0] row;
        logic [15:0]        color;
    } pix_req_t;

    function automatic logic [23:0] expand565(input logic [15:0] c);
        logic [23:0] r;
        logic [23:0] g;
        logic [23:0] b;
        r = {8'b0, c & RED_MASK} << 8;
        g = {8'b0, c & GREEN_MASK} << 5;
        b = {8'b0, c & BLUE_MASK} << 3;
        return r | g | b;
    endfunction

endpackage

FILE: design/lcdw_regs.sv
// ---------------------------------------------------------------------------
// lcdw_regs: panel size configuration registers
// APB-style write and read access to the panel width and height.
// ---------------------------------------------------------------------------
module lcdw_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lcdw_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [lcdw_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [lcdw_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    output lcdw_pkg::panel_t                 panel
);

    lcdw_pkg::panel_t panel_reg;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];
    assign panel   = panel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_reg.width  <= lcdw_pkg::PANEL_WIDTH_RESET;
            panel_reg.height <= lcdw_pkg::PANEL_HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                lcdw_pkg::REG_PANEL_WIDTH:
                begin
                    panel_reg.width <= pwdata[lcdw_pkg::PANEL_W-1:0];
                end
                lcdw_pkg::REG_PANEL_HEIGHT:
                begin
                    panel_reg.height <= pwdata[lcdw_pkg::PANEL_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            lcdw_pkg::REG_PANEL_WIDTH:
            begin
                prdata = lcdw_pkg::CFG_DATA_W'(panel_reg.width);
            end
            lcdw_pkg::REG_PANEL_HEIGHT:
            begin
                prdata = lcdw_pkg::CFG_DATA_W'(panel_reg.height);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

endmodule

FILE: design/lcdw_window.sv
// ---------------------------------------------------------------------------
// lcdw_window: window edges and auto-increment cursor
// Applies window commands, checks the cursor and steps it after each write.
// ---------------------------------------------------------------------------
module lcdw_window #(
    parameter int MAX_SIDE = lcdw_pkg::MAX_SIDE_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  lcdw_pkg::req_t     item,
    input  lcdw_pkg::panel_t   panel,
    output lcdw_pkg::pix_req_t pix
);

    localparam int EW = $clog2(MAX_SIDE + 1023);
    localparam logic [EW-1:0] SIDE_MAX = EW'(MAX_SIDE);
    localparam logic [EW-1:0] ONE      = EW'(1);

    logic [EW-1:0] left_reg,   left_next;
    logic [EW-1:0] top_reg,    top_next;
    logic [EW-1:0] right_reg,  right_next;
    logic [EW-1:0] bottom_reg, bottom_next;
    logic [EW-1:0] col_reg,    col_next;
    logic [EW-1:0] row_reg,    row_next;

    logic [EW-1:0] w_ext;
    logic [EW-1:0] h_ext;
    logic [EW-1:0] side_w;
    logic [EW-1:0] side_h;
    logic          in_window;
    logic          emit;

    assign w_ext = EW'(item.win_w);
    assign h_ext = EW'(item.win_h);

    always_comb
    begin
        if (w_ext == '0)
        begin
            side_w = ONE;
        end
        else if (w_ext > SIDE_MAX)
        begin
            side_w = SIDE_MAX;
        end
        else
        begin
            side_w = w_ext;
        end
        if (h_ext == '0)
        begin
            side_h = ONE;
        end
        else if (h_ext > SIDE_MAX)
        begin
            side_h = SIDE_MAX;
        end
        else
        begin
            side_h = h_ext;
        end
    end

    assign in_window = (col_reg >= left_reg) && (col_reg <= right_reg) &&
                       (row_reg >= top_reg) && (row_reg <= bottom_reg) &&
                       (col_reg < EW'(panel.width)) && (row_reg < EW'(panel.height));
    assign emit      = (item.req_type == lcdw_pkg::REQ_PIXEL) && in_window;

    always_comb
    begin
        left_next   = left_reg;
        top_next    = top_reg;
        right_next  = right_reg;
        bottom_next = bottom_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        case (item.req_type)
            lcdw_pkg::REQ_WINDOW:
            begin
                left_next   = EW'(item.win_x);
                top_next    = EW'(item.win_y);
                right_next  = EW'(item.win_x) + side_w - ONE;
                bottom_next = EW'(item.win_y) + side_h - ONE;
                col_next    = EW'(item.win_x);
                row_next    = EW'(item.win_y);
            end
            default:
            begin
                if (in_window)
                begin
                    if (col_reg == right_reg)
                    begin
                        col_next = left_reg;
                        row_next = (row_reg == bottom_reg) ? top_reg : row_reg + ONE;
                    end
                    else
                    begin
                        col_next = col_reg + ONE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (fire)
        begin
            left_reg   <= left_next;
            top_reg    <= top_next;
            right_reg  <= right_next;
            bottom_reg <= bottom_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    // Inside the panel, both coordinates fit the panel register width.
    assign pix.emit  = emit;
    assign pix.col   = col_reg[lcdw_pkg::PANEL_W-1:0];
    assign pix.row   = row_reg[lcdw_pkg::PANEL_W-1:0];
    assign pix.color = item.color565;

endmodule

FILE: design/lcdw_out.sv
// ---------------------------------------------------------------------------
// lcdw_out: address and color result register
// Forms the linear address and RGB888 color and holds the output beat.
// ---------------------------------------------------------------------------
module lcdw_out (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  lcdw_pkg::pix_req_t           pix,
    input  logic [lcdw_pkg::PANEL_W-1:0] panel_width,
    output logic                         free,
    output logic                         pix_valid,
    input  logic                         pix_ready,
    output lcdw_pkg::pix_t               pix_data
);

    localparam int PW = 2 * lcdw_pkg::PANEL_W;

    logic           valid_reg;
    lcdw_pkg::pix_t data_reg;
    logic [PW-1:0]  addr_full;

    assign addr_full = PW'(pix.row) * PW'(panel_width) + PW'(pix.col);
    assign free      = !valid_reg || pix_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg.pixel_address <= addr_full[19:0];
            data_reg.pixel_rgb888  <= lcdw_pkg::expand565(pix.color);
        end
    end

    assign pix_valid = valid_reg;
    assign pix_data  = data_reg;

endmodule

FILE: design/lcd_window_pixel_writer.sv
// ---------------------------------------------------------------------------
// lcd_window_pixel_writer: window-addressed pixel write path
// Window commands set the window and cursor; pixel beats produce addresses.
// ---------------------------------------------------------------------------
// Requests arrive on req_valid/req_ready with a req_t beat. A window beat
// (req_type 0) loads the window edges and moves the cursor to its top-left
// corner and produces nothing. A pixel beat produces one pix_t beat on
// pix_valid/pix_ready when the cursor lies inside both window and panel,
// and the cursor then steps along the row, wrapping by row and to the top.
// A pixel beat with the cursor outside is consumed and produces nothing.
// A request is held in the input register, where the cursor is checked and
// updated, and the address multiply then fills the output register, from
// which the result is presented. One request is taken per cycle unless the
// input register stalls; the cursor update loop in the window unit sets that
// rate. When pix_ready is low the output beat holds and the input register
// stalls only once it holds a pixel beat that would produce a result.
// The APB port sets panel width (address 0) and height (address 4); the user
// must write it only while the block is idle; the block does not enforce it.
// Reset empties both registers, clears the window and cursor to zero and sets
// the panel to 240 by 320.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lcd_window_pixel_writer #(
    parameter int MAX_SIDE = lcdw_pkg::MAX_SIDE_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  lcdw_pkg::req_t                  req_data,
    output logic                            pix_valid,
    input  logic                            pix_ready,
    output lcdw_pkg::pix_t                  pix_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lcdw_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [lcdw_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [lcdw_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    logic               stage_valid_reg;
    lcdw_pkg::req_t     stage_data_reg;
    lcdw_pkg::panel_t   panel;
    lcdw_pkg::pix_req_t pix_req;
    logic               out_free;
    logic               stage_fire;
    logic               out_load;

    assign stage_fire = stage_valid_reg && (!pix_req.emit || out_free);
    assign out_load   = stage_fire && pix_req.emit;
    assign req_ready  = !stage_valid_reg || stage_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            stage_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            stage_data_reg <= req_data;
        end
    end

    lcdw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .panel   (panel)
    );

    lcdw_window #(
        .MAX_SIDE (MAX_SIDE)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (stage_fire),
        .item  (stage_data_reg),
        .panel (panel),
        .pix   (pix_req)
    );

    lcdw_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (out_load),
        .pix         (pix_req),
        .panel_width (panel.width),
        .free        (out_free),
        .pix_valid   (pix_valid),
        .pix_ready   (pix_ready),
        .pix_data    (pix_data)
    );

    `LCDW_ASSERT(a_stall_only_on_full_out, stage_valid_reg && !stage_fire,
        pix_valid && !pix_ready, "input stage stalled without a blocked output")
    `LCDW_ASSERT_NEXT(a_load_shows_result, out_load, pix_valid,
        "loaded result not presented")
    `LCDW_ASSERT(a_rise_from_load, $rose(pix_valid), $past(out_load),
        "output beat appeared without a load")
    `LCDW_ASSERT(a_empty_stage_ready, !stage_valid_reg, req_ready,
        "empty input stage refused a request")

endmodule

FILE: tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: window pixel writer testbench
// Drives window and pixel beats through the valid/ready request channel,
// sets the panel size over the APB port between phases, and compares every
// output beat with a cycle-free model of the window cursor and address math.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int SEGMENTS = 7;

    class pixel_scoreboard;
        logic [10:0]     panel_w;
        logic [10:0]     panel_h;
        logic [10:0]     left_col;
        logic [10:0]     top_row;
        logic [10:0]     right_col;
        logic [10:0]     bottom_row;
        logic [10:0]     cur_col;
        logic [10:0]     cur_row;
        lcdw_pkg::pix_t  pixel_q[$];
        int              errors;
        int              accepted;
        int              checked;

        function new();
            panel_w = lcdw_pkg::PANEL_WIDTH_RESET;
            panel_h = lcdw_pkg::PANEL_HEIGHT_RESET;
            left_col = '0;
            top_row = '0;
            right_col = '0;
            bottom_row = '0;
            cur_col = '0;
            cur_row = '0;
            errors = 0;
            accepted = 0;
            checked = 0;
        endfunction

        function void set_panel(input logic idx, input logic [10:0] value);
            if (idx == lcdw_pkg::REG_PANEL_WIDTH)
                panel_w = value;
            else
                panel_h = value;
        endfunction

        function int pending();
            return pixel_q.size();
        endfunction

        function logic [10:0] clamp_side(input logic [10:0] s);
            if (s == 0)
                return 11'd1;
            if (s > lcdw_pkg::MAX_SIDE_DEFAULT)
                return 11'(lcdw_pkg::MAX_SIDE_DEFAULT);
            return s;
        endfunction

        function void note_request(input lcdw_pkg::req_t r);
            logic [31:0]    addr;
            lcdw_pkg::pix_t p;
            accepted++;
            if (r.req_type == lcdw_pkg::REQ_WINDOW)
            begin
                left_col = {1'b0, r.win_x};
                top_row = {1'b0, r.win_y};
                right_col = {1'b0, r.win_x} + clamp_side(r.win_w) - 11'd1;
                bottom_row = {1'b0, r.win_y} + clamp_side(r.win_h) - 11'd1;
                cur_col = {1'b0, r.win_x};
                cur_row = {1'b0, r.win_y};
            end
            else if (cur_col >= left_col && cur_col <= right_col &&
                     cur_row >= top_row && cur_row <= bottom_row &&
                     cur_col < panel_w && cur_row < panel_h)
            begin
                addr = 32'(cur_row) * 32'(panel_w) + 32'(cur_col);
                p.pixel_address = addr[19:0];
                p.pixel_rgb888 = {r.color565[15:11], 3'b000, r.color565[10:5], 2'b00,
                                  r.color565[4:0], 3'b000};
                pixel_q.push_back(p);
                if (cur_col == right_col)
                begin
                    cur_col = left_col;
                    cur_row = (cur_row == bottom_row) ? top_row : cur_row + 11'd1;
                end
                else
                begin
                    cur_col = cur_col + 11'd1;
                end
            end
        endfunction

        task report(input string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_pixel(input lcdw_pkg::pix_t got);
            lcdw_pkg::pix_t want;
            if (pixel_q.size() == 0)
            begin
                report($sformatf("pixel beat addr %0d with none expected", got.pixel_address));
            end
            else
            begin
                want = pixel_q.pop_front();
                checked++;
                if (got.pixel_address !== want.pixel_address)
                    report($sformatf("beat %0d address got %0d want %0d", checked,
                                     got.pixel_address, want.pixel_address));
                if (got.pixel_rgb888 !== want.pixel_rgb888)
                    report($sformatf("beat %0d rgb got %06h want %06h", checked,
                                     got.pixel_rgb888, want.pixel_rgb888));
            end
        endtask
    endclass

    logic                            clk;
    logic                            rst_n = 1'b0;
    logic                            req_valid = 1'b0;
    logic                            req_ready;
    lcdw_pkg::req_t                  req_data = '0;
    logic                            pix_valid;
    logic                            pix_ready = 1'b0;
    lcdw_pkg::pix_t                  pix_data;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [lcdw_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [lcdw_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [lcdw_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    pixel_scoreboard sb = new();
    int              cycles = 0;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              seg_pw[SEGMENTS] = '{64, 1, 2047, 0, 300, -1, 1024};
    int              seg_ph[SEGMENTS] = '{48, 1, 2047, 500, 0, -1, 1024};
    int              seg_items[SEGMENTS] = '{250, 100, 250, 60, 60, 250, 230};

    lcd_window_pixel_writer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data (req_data),
        .pix_valid(pix_valid),
        .pix_ready(pix_ready),
        .pix_data (pix_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        pix_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_valid && pix_ready)
                sb.check_pixel(pix_data);
            if (req_valid && req_ready)
                sb.note_request(req_data);
        end
    end

    task automatic send_request(input lcdw_pkg::req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic send_window(input int x, input int y, input int w, input int h);
        lcdw_pkg::req_t r;
        r.req_type = lcdw_pkg::REQ_WINDOW;
        r.win_x = 10'(x);
        r.win_y = 10'(y);
        r.win_w = 11'(w);
        r.win_h = 11'(h);
        r.color565 = 16'($urandom);
        send_request(r);
    endtask

    task automatic send_pixel(input logic [15:0] color);
        lcdw_pkg::req_t r;
        r.req_type = lcdw_pkg::REQ_PIXEL;
        r.win_x = 10'($urandom);
        r.win_y = 10'($urandom);
        r.win_w = 11'($urandom);
        r.win_h = 11'($urandom);
        r.color565 = color;
        send_request(r);
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_panel(input logic idx, input logic [10:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {21'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.set_panel(idx, value);
    endtask

    function automatic int pick_side();
        int k;
        k = $urandom_range(99);
        if (k < 70)
            return $urandom_range(1, 6);
        if (k < 80)
            return $urandom_range(7, 40);
        if (k < 86)
            return 0;
        if (k < 92)
            return $urandom_range(1025, 2047);
        return $urandom_range(0, 2047);
    endfunction

    function automatic int pick_origin(input int extent);
        int lim;
        lim = (extent == 0) ? 0 : ((extent > 1024) ? 1023 : extent - 1);
        if ($urandom_range(99) < 90)
            return $urandom_range(0, lim);
        return $urandom_range(0, 1023);
    endfunction

    task automatic run_segment(input int count);
        int             sent;
        int             k;
        int             w;
        int             h;
        int             n;
        logic [63:0]    raw;
        lcdw_pkg::req_t r;
        sent = 0;
        while (sent < count)
        begin
            k = $urandom_range(99);
            if (k < 8)
            begin
                raw = {$urandom, $urandom};
                r = raw[$bits(lcdw_pkg::req_t)-1:0];
                send_request(r);
                sent++;
            end
            else if (k < 9)
            begin
                wait_idle();
            end
            else
            begin
                w = pick_side();
                h = pick_side();
                send_window(pick_origin(sb.panel_w), pick_origin(sb.panel_h), w, h);
                sent++;
                n = int'(sb.clamp_side(11'(w))) * int'(sb.clamp_side(11'(h)))
                    + $urandom_range(0, 2);
                if (n > 24)
                    n = $urandom_range(8, 24);
                repeat (n)
                begin
                    send_pixel(16'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        int pw;
        int ph;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 13;
        recv_stall_pct = 78;

        send_pixel(16'hffff);
        send_pixel(16'h0000);
        send_window(1023, 1023, 1, 1);
        send_pixel(16'h1234);
        send_window(238, 318, 2, 2);
        send_pixel(16'hf800);
        send_pixel(16'h07e0);
        send_pixel(16'h001f);
        send_pixel(16'h0000);
        send_pixel(16'hffff);
        send_window(5, 5, 0, 0);
        send_pixel(16'ha5a5);
        send_pixel(16'h5a5a);
        send_window(0, 0, 2047, 2047);
        send_pixel(16'hffff);
        send_pixel(16'h8001);
        send_window(235, 10, 10, 1);
        repeat (7) send_pixel(16'($urandom));
        wait_idle();

        for (int s = 0; s < SEGMENTS; s++)
        begin
            send_idle_pct = (s < 2) ? 13 : ((s < 4) ? 78 : 0);
            recv_stall_pct = (s < 2) ? 78 : ((s < 4) ? 13 : 0);
            pw = (seg_pw[s] < 0) ? $urandom_range(1, 1024) : seg_pw[s];
            ph = (seg_ph[s] < 0) ? $urandom_range(1, 1024) : seg_ph[s];
            write_panel(lcdw_pkg::REG_PANEL_WIDTH, 11'(pw));
            write_panel(lcdw_pkg::REG_PANEL_HEIGHT, 11'(ph));
            run_segment(seg_items[s]);
            wait_idle();
        end

        $display("covered %0d request beats and %0d pixel beats over %0d panel sizes",
                 sb.accepted, sb.checked, SEGMENTS + 1);
        $display("idling mixes: slow receiver, slow sender, then full rate");
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

FILE: lcd_window_pixel_writer.f
+incdir+design
design/lcdw_pkg.sv
design/lcdw_regs.sv
design/lcdw_window.sv
design/lcdw_out.sv
design/lcd_window_pixel_writer.sv
tb/sv/tb_top.sv
